// ===== rtl/i2cram_pkg.sv =====
`timescale 1ns / 1ps

package i2cram_pkg;

    localparam int TIMER_BITS = 16;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    // Request codes on the req_type field.
    localparam logic [1:0] REQ_CODE_WRITE = 2'd1;
    localparam logic [1:0] REQ_CODE_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HALF_BIT    = 2'd0;
    localparam logic [1:0] CFG_EDGE        = 2'd1;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_DEV_ADDR    = 2'd3;

    localparam logic [7:0]  RST_HALF_BIT    = 8'd2;
    localparam logic [7:0]  RST_EDGE        = 8'd4;
    localparam logic [15:0] RST_ACK_TIMEOUT = 16'd500;
    localparam logic [6:0]  RST_DEV_ADDR    = 7'h10;

    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        REQ_TICK,
        REQ_WRITE,
        REQ_READ
    } t_req;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_TX_LO1,
        PH_TX_HI,
        PH_TX_LO2,
        PH_ACK_HI,
        PH_ACK_POL,
        PH_ACK_LO,
        PH_RX_LO1,
        PH_RX_HI,
        PH_RX_LO2,
        PH_NK_HI,
        PH_NK_LO,
        PH_SP_A,
        PH_SP_B
    } t_phase;

    typedef struct packed {
        t_req       req;
        logic [7:0] reg_addr;
        logic [7:0] write_value;
        logic       sda_sample;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy;
        logic       done;
        logic       failed;
        logic [7:0] read_data;
    } t_result;

    typedef struct packed {
        logic [7:0]  half_bit_ticks;
        logic [7:0]  edge_ticks;
        logic [15:0] ack_timeout_ticks;
        logic [6:0]  device_address;
    } t_cfg;

endpackage

// ===== rtl/i2cram_front.sv =====
`timescale 1ns / 1ps

module i2cram_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_reg_addr,
    input  logic [7:0]         i_write_value,
    input  logic               i_sda_sample,
    output logic               o_full,
    output logic               o_valid,
    output i2cram_pkg::t_item  o_item,
    input  logic               i_take
);

    i2cram_pkg::t_item r_mem [2];
    i2cram_pkg::t_item w_class;
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              w_push;
    logic              w_pop;

    // Code 3 carries no request and is handled as a plain tick.
    always_comb begin
        w_class.reg_addr    = i_reg_addr;
        w_class.write_value = i_write_value;
        w_class.sda_sample  = i_sda_sample;
        case (i_req_type)
            i2cram_pkg::REQ_CODE_WRITE: w_class.req = i2cram_pkg::REQ_WRITE;
            i2cram_pkg::REQ_CODE_READ:  w_class.req = i2cram_pkg::REQ_READ;
            default:                    w_class.req = i2cram_pkg::REQ_TICK;
        endcase
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/i2cram_seq.sv =====
`timescale 1ns / 1ps

module i2cram_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  i2cram_pkg::t_item    i_item,
    output logic                 o_take,
    input  i2cram_pkg::t_cfg     i_cfg,
    input  logic                 i_space,
    output logic                 o_res_valid,
    output i2cram_pkg::t_result  o_result
);

    localparam int TB = i2cram_pkg::TIMER_BITS;

    i2cram_pkg::t_phase r_phase, n_phase, e_phase;
    logic [TB-1:0]      r_wait, n_wait, e_wait;
    logic [3:0]         r_bit, n_bit, e_bit;
    logic [1:0]         r_bidx, n_bidx, e_bidx;
    logic [7:0]         r_shift, n_shift;
    logic [7:0]         r_preg, n_preg, e_preg;
    logic [7:0]         r_pval, n_pval, e_pval;
    logic               r_is_read, n_is_read, e_is_read;
    logic               r_fail, n_fail, e_fail;
    logic [7:0]         r_last_read, n_last_read;

    logic               w_start;
    logic [TB-1:0]      w_len;
    logic [TB-1:0]      w_len1;
    logic [TB-1:0]      w_inc;
    logic               w_expired;
    logic [TB-1:0]      w_tnext;
    logic               w_done;
    logic               w_tx_pull;
    logic               w_sda;

    assign o_take      = i_valid && i_space;
    assign o_res_valid = o_take;
    assign w_sda       = i_item.sda_sample;

    // A request on an idle tick already runs as the first START tick.
    always_comb begin
        w_start   = (r_phase == i2cram_pkg::PH_IDLE) && (i_item.req != i2cram_pkg::REQ_TICK);
        e_phase   = w_start ? i2cram_pkg::PH_ST_A : r_phase;
        e_wait    = w_start ? '0 : r_wait;
        e_bit     = w_start ? 4'd0 : r_bit;
        e_bidx    = w_start ? 2'd0 : r_bidx;
        e_is_read = w_start ? (i_item.req == i2cram_pkg::REQ_READ) : r_is_read;
        e_fail    = w_start ? 1'b0 : r_fail;
        e_preg    = w_start ? i_item.reg_addr : r_preg;
        e_pval    = w_start ? i_item.write_value : r_pval;
    end

    // Phase timer: saturating count, a zero length acts as one.
    always_comb begin
        case (e_phase)
            i2cram_pkg::PH_ST_A, i2cram_pkg::PH_ST_B,
            i2cram_pkg::PH_SP_A, i2cram_pkg::PH_SP_B:
                w_len = TB'(i_cfg.edge_ticks);
            i2cram_pkg::PH_ACK_POL:
                w_len = TB'(i_cfg.ack_timeout_ticks);
            default:
                w_len = TB'(i_cfg.half_bit_ticks);
        endcase
        w_len1    = (w_len == '0) ? TB'(1) : w_len;
        w_inc     = (e_wait == i2cram_pkg::TIMER_MAX) ? e_wait : e_wait + TB'(1);
        w_expired = (w_inc >= w_len1) || (w_inc == i2cram_pkg::TIMER_MAX);
        w_tnext   = w_expired ? '0 : w_inc;
    end

    // Next state.
    always_comb begin
        n_phase     = e_phase;
        n_wait      = e_wait;
        n_bit       = e_bit;
        n_bidx      = e_bidx;
        n_shift     = r_shift;
        n_preg      = e_preg;
        n_pval      = e_pval;
        n_is_read   = e_is_read;
        n_fail      = e_fail;
        n_last_read = r_last_read;
        w_done      = 1'b0;
        case (e_phase)
            i2cram_pkg::PH_IDLE: begin
                n_phase = i2cram_pkg::PH_IDLE;
            end
            i2cram_pkg::PH_ST_A: begin
                n_wait = w_tnext;
                if (w_expired) n_phase = i2cram_pkg::PH_ST_B;
            end
            i2cram_pkg::PH_ST_B: begin
                n_wait = w_tnext;
                if (w_expired) begin
                    n_shift = {i_cfg.device_address, (e_bidx != 2'd0)};
                    n_bit   = 4'd0;
                    n_phase = i2cram_pkg::PH_TX_LO1;
                end
            end
            i2cram_pkg::PH_TX_LO1: begin
                n_wait = w_tnext;
                if (w_expired) n_phase = i2cram_pkg::PH_TX_HI;
            end
            i2cram_pkg::PH_TX_HI: begin
                n_wait = w_tnext;
                if (w_expired) n_phase = i2cram_pkg::PH_TX_LO2;
            end
            i2cram_pkg::PH_TX_LO2: begin
                n_wait = w_tnext;
                if (w_expired) begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = e_bit + 4'd1;
                    n_phase = (e_bit + 4'd1 >= 4'd8) ? i2cram_pkg::PH_ACK_HI
                                                     : i2cram_pkg::PH_TX_LO1;
                end
            end
            i2cram_pkg::PH_ACK_HI: begin
                n_wait = w_tnext;
                if (w_expired) n_phase = i2cram_pkg::PH_ACK_POL;
            end
            i2cram_pkg::PH_ACK_POL: begin
                if (!w_sda) begin
                    n_wait  = '0;
                    n_phase = i2cram_pkg::PH_ACK_LO;
                end else begin
                    n_wait = w_tnext;
                    if (w_expired) begin
                        n_fail  = 1'b1;
                        n_phase = i2cram_pkg::PH_ACK_LO;
                    end
                end
            end
            i2cram_pkg::PH_ACK_LO: begin
                n_wait = w_tnext;
                if (w_expired) begin
                    if (e_fail) begin
                        n_phase = i2cram_pkg::PH_SP_A;
                    end else if (e_bidx == 2'd0) begin
                        n_bidx  = 2'd1;
                        n_shift = e_preg;
                        n_bit   = 4'd0;
                        n_phase = i2cram_pkg::PH_TX_LO1;
                    end else if (e_bidx == 2'd1) begin
                        n_bidx = 2'd2;
                        if (e_is_read) begin
                            n_phase = i2cram_pkg::PH_ST_A;
                        end else begin
                            n_shift = e_pval;
                            n_bit   = 4'd0;
                            n_phase = i2cram_pkg::PH_TX_LO1;
                        end
                    end else if (e_bidx == 2'd2 && e_is_read) begin
                        n_bidx  = 2'd3;
                        n_shift = 8'd0;
                        n_bit   = 4'd0;
                        n_phase = i2cram_pkg::PH_RX_LO1;
                    end else begin
                        n_phase = i2cram_pkg::PH_SP_A;
                    end
                end
            end
            i2cram_pkg::PH_RX_LO1: begin
                n_wait = w_tnext;
                if (w_expired) n_phase = i2cram_pkg::PH_RX_HI;
            end
            i2cram_pkg::PH_RX_HI: begin
                n_wait = w_tnext;
                if (w_expired) begin
                    n_shift = {r_shift[6:0], w_sda};
                    n_phase = i2cram_pkg::PH_RX_LO2;
                end
            end
            i2cram_pkg::PH_RX_LO2: begin
                n_wait = w_tnext;
                if (w_expired) begin
                    n_bit   = e_bit + 4'd1;
                    n_phase = (e_bit + 4'd1 >= 4'd8) ? i2cram_pkg::PH_NK_HI
                                                     : i2cram_pkg::PH_RX_LO1;
                end
            end
            i2cram_pkg::PH_NK_HI: begin
                n_wait = w_tnext;
                if (w_expired) n_phase = i2cram_pkg::PH_NK_LO;
            end
            i2cram_pkg::PH_NK_LO: begin
                n_wait = w_tnext;
                if (w_expired) n_phase = i2cram_pkg::PH_SP_A;
            end
            i2cram_pkg::PH_SP_A: begin
                n_wait = w_tnext;
                if (w_expired) n_phase = i2cram_pkg::PH_SP_B;
            end
            default: begin
                n_wait = w_tnext;
                if (w_expired) begin
                    w_done = 1'b1;
                    if (e_is_read) n_last_read = e_fail ? 8'd0 : r_shift;
                    n_phase = i2cram_pkg::PH_IDLE;
                end
            end
        endcase
    end

    // Line levels and status for this tick.
    always_comb begin
        w_tx_pull             = ~r_shift[7];
        o_result.scl_level    = 1'b1;
        o_result.sda_pull_low = 1'b0;
        o_result.busy         = (e_phase != i2cram_pkg::PH_IDLE);
        o_result.done         = w_done;
        o_result.failed       = w_done && e_fail;
        o_result.read_data    = n_last_read;
        case (e_phase)
            i2cram_pkg::PH_ST_B, i2cram_pkg::PH_SP_A: begin
                o_result.sda_pull_low = 1'b1;
            end
            i2cram_pkg::PH_TX_LO1, i2cram_pkg::PH_TX_LO2: begin
                o_result.scl_level    = 1'b0;
                o_result.sda_pull_low = w_tx_pull;
            end
            i2cram_pkg::PH_TX_HI: begin
                o_result.sda_pull_low = w_tx_pull;
            end
            i2cram_pkg::PH_ACK_LO, i2cram_pkg::PH_RX_LO1,
            i2cram_pkg::PH_RX_LO2, i2cram_pkg::PH_NK_LO: begin
                o_result.scl_level = 1'b0;
            end
            default: begin
                o_result.scl_level = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cram_pkg::PH_IDLE;
            r_wait      <= '0;
            r_bit       <= 4'd0;
            r_bidx      <= 2'd0;
            r_shift     <= 8'd0;
            r_preg      <= 8'd0;
            r_pval      <= 8'd0;
            r_is_read   <= 1'b0;
            r_fail      <= 1'b0;
            r_last_read <= 8'd0;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_wait      <= n_wait;
            r_bit       <= n_bit;
            r_bidx      <= n_bidx;
            r_shift     <= n_shift;
            r_preg      <= n_preg;
            r_pval      <= n_pval;
            r_is_read   <= n_is_read;
            r_fail      <= n_fail;
            r_last_read <= n_last_read;
        end
    end

endmodule

// ===== rtl/i2cram_outq.sv =====
`timescale 1ns / 1ps

module i2cram_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  i2cram_pkg::t_result  i_result,
    output logic                 o_space,
    output logic                 o_empty,
    output i2cram_pkg::t_result  o_head,
    input  logic                 i_pop
);

    i2cram_pkg::t_result r_mem [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic                w_push;
    logic                w_pop;

    assign o_space = (r_count != 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_space;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/i2c_register_access_master.sv =====
`timescale 1ns / 1ps
// Tick-driven I2C master for single-byte register writes and reads.
// Every request pushed on the input side is one bus tick: it carries a
// request type (plain tick, register write or register read), the register
// number, the write value and the sampled SDA level. Each tick yields exactly
// one result on the output side with the SCL and SDA drive for that tick,
// busy, done, failed and the byte of the last finished read.
// Requests enter a two-entry queue, the sequencer runs one tick per clock,
// and results leave through a two-entry queue. With pop held high, a result
// leaves at the next edge. One request per clock is sustained while results
// are popped; the limit is the single-tick update of the phase sequencer.
// When the receiver stops popping, the result queue fills, the sequencer
// holds its state, and full rises once the request queue is full; no tick
// is lost or repeated. Configuration (half-bit ticks, edge ticks, acknowledge
// timeout, device address) is written through i_cfg_we/i_cfg_index/i_cfg_data
// by the user only while idle; the block itself does not enforce it.
// Synchronous active-low reset empties both queues, puts the sequencer in
// idle with all counters cleared, and loads the default timing and address.

module i2c_register_access_master (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_req_type,
    input  logic [7:0]                        i_reg_addr,
    input  logic [7:0]                        i_write_value,
    input  logic                              i_sda_sample,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_scl_level,
    output logic                              o_sda_pull_low,
    output logic                              o_busy_res,
    output logic                              o_done_res,
    output logic                              o_failed,
    output logic [7:0]                        o_read_data,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [i2cram_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    i2cram_pkg::t_cfg    r_cfg;
    i2cram_pkg::t_item   w_item;
    i2cram_pkg::t_result w_result;
    i2cram_pkg::t_result w_head;
    logic                w_item_valid;
    logic                w_take;
    logic                w_space;
    logic                w_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit_ticks    <= i2cram_pkg::RST_HALF_BIT;
            r_cfg.edge_ticks        <= i2cram_pkg::RST_EDGE;
            r_cfg.ack_timeout_ticks <= i2cram_pkg::RST_ACK_TIMEOUT;
            r_cfg.device_address    <= i2cram_pkg::RST_DEV_ADDR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cram_pkg::CFG_HALF_BIT:    r_cfg.half_bit_ticks    <= i_cfg_data[7:0];
                i2cram_pkg::CFG_EDGE:        r_cfg.edge_ticks        <= i_cfg_data[7:0];
                i2cram_pkg::CFG_ACK_TIMEOUT: r_cfg.ack_timeout_ticks <= i_cfg_data;
                i2cram_pkg::CFG_DEV_ADDR:    r_cfg.device_address    <= i_cfg_data[6:0];
                default:                     r_cfg                   <= r_cfg;
            endcase
        end
    end

    i2cram_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_req_type    (i_req_type),
        .i_reg_addr    (i_reg_addr),
        .i_write_value (i_write_value),
        .i_sda_sample  (i_sda_sample),
        .o_full        (full),
        .o_valid       (w_item_valid),
        .o_item        (w_item),
        .i_take        (w_take)
    );

    i2cram_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_item_valid),
        .i_item      (w_item),
        .o_take      (w_take),
        .i_cfg       (r_cfg),
        .i_space     (w_space),
        .o_res_valid (w_res_valid),
        .o_result    (w_result)
    );

    i2cram_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_valid),
        .i_result (w_result),
        .o_space  (w_space),
        .o_empty  (empty),
        .o_head   (w_head),
        .i_pop    (pop)
    );

    assign o_scl_level    = w_head.scl_level;
    assign o_sda_pull_low = w_head.sda_pull_low;
    assign o_busy_res     = w_head.busy;
    assign o_done_res     = w_head.done;
    assign o_failed       = w_head.failed;
    assign o_read_data    = w_head.read_data;

endmodule

// ===== sim/i2c_bus_checker.sv =====
`timescale 1ns / 1ps

module i2c_bus_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_reg_addr,
    input  logic [7:0]  i_write_value,
    input  logic        i_sda_sample,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_scl_level,
    input  logic        i_sda_pull_low,
    input  logic        i_busy,
    input  logic        i_done,
    input  logic        i_failed,
    input  logic [7:0]  i_read_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_cnt,
    output int          o_pending
);
    import i2cram_pkg::*;

    // Which byte of the transaction is on the bus.
    localparam logic [1:0] FRAME_ADDR = 2'd0;
    localparam logic [1:0] FRAME_REG  = 2'd1;
    localparam logic [1:0] FRAME_DATA = 2'd2;
    localparam logic [1:0] FRAME_RX   = 2'd3;

    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    t_cfg        cfg_now;
    t_phase      ph;
    logic [3:0]  bits_done;
    logic [15:0] tick_cnt;
    logic [7:0]  shreg;
    logic [7:0]  held_reg;
    logic [7:0]  held_val;
    logic        rd_mode;
    logic        nack_seen;
    logic [7:0]  last_rd;
    logic [1:0]  byte_no;

    t_result bus_ticks_due[$];
    int      tick_no;

    // Counts one tick of a timed span and reports when the span is over.
    function automatic logic span_done(input logic [15:0] len);
        logic [15:0] lim;
        lim = (len == 16'd0) ? 16'd1 : len;
        if (tick_cnt != TIMER_MAX)
            tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= lim || tick_cnt == TIMER_MAX) begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void move_to(input t_phase p);
        ph = p;
        tick_cnt = '0;
    endfunction

    function automatic void load_tx(input logic [7:0] b);
        shreg = b;
        bits_done = '0;
        move_to(PH_TX_LO1);
    endfunction

    function automatic void next_frame();
        case (byte_no)
            FRAME_ADDR: begin
                byte_no = FRAME_REG;
                load_tx(held_reg);
            end
            FRAME_REG: begin
                byte_no = FRAME_DATA;
                if (rd_mode)
                    move_to(PH_ST_A);
                else
                    load_tx(held_val);
            end
            FRAME_DATA: begin
                if (rd_mode) begin
                    byte_no = FRAME_RX;
                    shreg = '0;
                    bits_done = '0;
                    move_to(PH_RX_LO1);
                end else begin
                    move_to(PH_SP_A);
                end
            end
            default: move_to(PH_SP_A);
        endcase
    endfunction

    function automatic t_result bus_tick_predict(input logic [1:0] req, input logic [7:0] ra,
                                                 input logic [7:0] wv, input logic sda);
        t_result r;
        logic    tx_pull;
        r = '0;
        r.scl_level = 1'b1;
        if (ph == PH_IDLE && (req == REQ_CODE_WRITE || req == REQ_CODE_READ)) begin
            held_reg = ra;
            held_val = wv;
            rd_mode = (req == REQ_CODE_READ);
            nack_seen = 1'b0;
            byte_no = FRAME_ADDR;
            bits_done = '0;
            move_to(PH_ST_A);
        end
        if (ph != PH_IDLE) begin
            tx_pull = ~shreg[7];
            r.busy = 1'b1;
            case (ph)
                PH_ST_A: begin
                    if (span_done(16'(cfg_now.edge_ticks)))
                        move_to(PH_ST_B);
                end
                PH_ST_B: begin
                    r.sda_pull_low = 1'b1;
                    if (span_done(16'(cfg_now.edge_ticks)))
                        load_tx({cfg_now.device_address,
                                 (byte_no == FRAME_ADDR) ? RW_WRITE : RW_READ});
                end
                PH_TX_LO1: begin
                    r.scl_level = 1'b0;
                    r.sda_pull_low = tx_pull;
                    if (span_done(16'(cfg_now.half_bit_ticks)))
                        move_to(PH_TX_HI);
                end
                PH_TX_HI: begin
                    r.sda_pull_low = tx_pull;
                    if (span_done(16'(cfg_now.half_bit_ticks)))
                        move_to(PH_TX_LO2);
                end
                PH_TX_LO2: begin
                    r.scl_level = 1'b0;
                    r.sda_pull_low = tx_pull;
                    if (span_done(16'(cfg_now.half_bit_ticks))) begin
                        shreg = shreg << 1;
                        bits_done = bits_done + 4'd1;
                        move_to(bits_done >= 4'd8 ? PH_ACK_HI : PH_TX_LO1);
                    end
                end
                PH_ACK_HI: begin
                    if (span_done(16'(cfg_now.half_bit_ticks)))
                        move_to(PH_ACK_POL);
                end
                PH_ACK_POL: begin
                    if (!sda) begin
                        move_to(PH_ACK_LO);
                    end else if (span_done(cfg_now.ack_timeout_ticks)) begin
                        nack_seen = 1'b1;
                        move_to(PH_ACK_LO);
                    end
                end
                PH_ACK_LO: begin
                    r.scl_level = 1'b0;
                    if (span_done(16'(cfg_now.half_bit_ticks))) begin
                        if (nack_seen)
                            move_to(PH_SP_A);
                        else
                            next_frame();
                    end
                end
                PH_RX_LO1: begin
                    r.scl_level = 1'b0;
                    if (span_done(16'(cfg_now.half_bit_ticks)))
                        move_to(PH_RX_HI);
                end
                PH_RX_HI: begin
                    if (span_done(16'(cfg_now.half_bit_ticks))) begin
                        shreg = {shreg[6:0], sda};
                        move_to(PH_RX_LO2);
                    end
                end
                PH_RX_LO2: begin
                    r.scl_level = 1'b0;
                    if (span_done(16'(cfg_now.half_bit_ticks))) begin
                        bits_done = bits_done + 4'd1;
                        move_to(bits_done >= 4'd8 ? PH_NK_HI : PH_RX_LO1);
                    end
                end
                PH_NK_HI: begin
                    if (span_done(16'(cfg_now.half_bit_ticks)))
                        move_to(PH_NK_LO);
                end
                PH_NK_LO: begin
                    r.scl_level = 1'b0;
                    if (span_done(16'(cfg_now.half_bit_ticks)))
                        move_to(PH_SP_A);
                end
                PH_SP_A: begin
                    r.sda_pull_low = 1'b1;
                    if (span_done(16'(cfg_now.edge_ticks)))
                        move_to(PH_SP_B);
                end
                PH_SP_B: begin
                    if (span_done(16'(cfg_now.edge_ticks))) begin
                        r.done = 1'b1;
                        r.failed = nack_seen;
                        if (rd_mode)
                            last_rd = nack_seen ? 8'd0 : shreg;
                        move_to(PH_IDLE);
                    end
                end
                default: ;
            endcase
        end
        r.read_data = last_rd;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            cfg_now.half_bit_ticks = RST_HALF_BIT;
            cfg_now.edge_ticks = RST_EDGE;
            cfg_now.ack_timeout_ticks = RST_ACK_TIMEOUT;
            cfg_now.device_address = RST_DEV_ADDR;
            ph = PH_IDLE;
            bits_done = '0;
            tick_cnt = '0;
            shreg = '0;
            held_reg = '0;
            held_val = '0;
            rd_mode = 1'b0;
            nack_seen = 1'b0;
            last_rd = '0;
            byte_no = FRAME_ADDR;
            bus_ticks_due.delete();
            tick_no = 0;
            o_fail_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HALF_BIT:    cfg_now.half_bit_ticks = i_cfg_data[7:0];
                    CFG_EDGE:        cfg_now.edge_ticks = i_cfg_data[7:0];
                    CFG_ACK_TIMEOUT: cfg_now.ack_timeout_ticks = i_cfg_data;
                    CFG_DEV_ADDR:    cfg_now.device_address = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                bus_ticks_due.push_back(bus_tick_predict(i_req_type, i_reg_addr,
                                                         i_write_value, i_sda_sample));
            if (i_pop && !i_empty) begin
                seen.scl_level = i_scl_level;
                seen.sda_pull_low = i_sda_pull_low;
                seen.busy = i_busy;
                seen.done = i_done;
                seen.failed = i_failed;
                seen.read_data = i_read_data;
                if (bus_ticks_due.size() == 0) begin
                    o_fail_cnt++;
                    if (o_fail_cnt <= 10)
                        $display("tick %0d: result with no request outstanding", tick_no);
                end else begin
                    want = bus_ticks_due.pop_front();
                    if (seen.scl_level !== want.scl_level || seen.sda_pull_low !== want.sda_pull_low
                        || seen.busy !== want.busy || seen.done !== want.done
                        || seen.failed !== want.failed || seen.read_data !== want.read_data) begin
                        o_fail_cnt++;
                        if (o_fail_cnt <= 10)
                            $display({"tick %0d: expected scl=%b sda_low=%b busy=%b done=%b ",
                                      "failed=%b data=%h, got scl=%b sda_low=%b busy=%b ",
                                      "done=%b failed=%b data=%h"}, tick_no,
                                     want.scl_level, want.sda_pull_low, want.busy, want.done,
                                     want.failed, want.read_data, seen.scl_level,
                                     seen.sda_pull_low, seen.busy, seen.done, seen.failed,
                                     seen.read_data);
                    end
                end
                tick_no++;
            end
        end
        o_pending = bus_ticks_due.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import i2cram_pkg::*;

    // A request code the block treats as a plain tick.
    localparam logic [1:0] REQ_CODE_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_req_type;
    logic [7:0]  i_reg_addr;
    logic [7:0]  i_write_value;
    logic        i_sda_sample;
    logic        empty;
    logic        pop;
    logic        o_scl_level;
    logic        o_sda_pull_low;
    logic        o_busy_res;
    logic        o_done_res;
    logic        o_failed;
    logic [7:0]  o_read_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int   fail_cnt;
    int   pending;
    int   n_pushed;
    int   n_req;
    int   n_popped;
    int   n_done;
    logic bus_open;
    logic quiet;
    logic hold_taken;
    int   hold_cnt;
    int   stall_cnt;
    logic [7:0] win_cnt;

    always #4 i_clk = ~i_clk;

    i2c_register_access_master uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_reg_addr    (i_reg_addr),
        .i_write_value (i_write_value),
        .i_sda_sample  (i_sda_sample),
        .empty         (empty),
        .pop           (pop),
        .o_scl_level   (o_scl_level),
        .o_sda_pull_low(o_sda_pull_low),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_failed      (o_failed),
        .o_read_data   (o_read_data),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    i2c_bus_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_req_type    (i_req_type),
        .i_reg_addr    (i_reg_addr),
        .i_write_value (i_write_value),
        .i_sda_sample  (i_sda_sample),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_scl_level   (o_scl_level),
        .i_sda_pull_low(o_sda_pull_low),
        .i_busy        (o_busy_res),
        .i_done        (o_done_res),
        .i_failed      (o_failed),
        .i_read_data   (o_read_data),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_cnt    (fail_cnt),
        .o_pending     (pending)
    );

    // Result side: random stall bursts, calm windows, and one long hold-off
    // that lets the block fill up and push back on the request side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            n_popped <= 0;
            n_done <= 0;
            bus_open <= 1'b0;
            hold_taken <= 1'b0;
            hold_cnt <= 0;
            stall_cnt <= 0;
            win_cnt <= '0;
        end else begin
            if (pop && !empty) begin
                n_popped <= n_popped + 1;
                bus_open <= o_busy_res && !o_done_res;
                if (o_done_res)
                    n_done <= n_done + 1;
            end
            win_cnt <= win_cnt + 8'd1;
            if (hold_cnt != 0) begin
                pop <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end else if (!hold_taken && !quiet && n_popped >= 250) begin
                hold_taken <= 1'b1;
                hold_cnt <= 300;
                pop <= 1'b0;
            end else if (stall_cnt != 0) begin
                pop <= 1'b0;
                stall_cnt <= stall_cnt - 1;
            end else if (!quiet && win_cnt < 8'd150 && $urandom_range(0, 11) == 0) begin
                pop <= 1'b0;
                stall_cnt <= $urandom_range(0, 11);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic logic ack_level(input int pct_low);
        return ($urandom_range(0, 99) < pct_low) ? 1'b0 : 1'b1;
    endfunction

    function automatic int pick_ack_pct();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 100;
        else if (r < 7)
            return 85;
        else if (r < 9)
            return 50;
        return 0;
    endfunction

    task automatic send_item(input logic [1:0] req, input logic [7:0] ra, input logic [7:0] wv,
                             input logic sda);
        if (!quiet && (n_pushed % 256) < 170 && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_req_type <= req;
        i_reg_addr <= ra;
        i_write_value <= wv;
        i_sda_sample <= sda;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        n_pushed++;
    endtask

    // Issues one request and keeps ticking until a finished transaction
    // comes back; with noise set, stray requests land while the bus is busy.
    task automatic run_txn(input logic [1:0] req, input logic [7:0] ra, input logic [7:0] wv,
                           input int pct_low, input logic noise);
        int seen;
        seen = n_done;
        n_req++;
        send_item(req, ra, wv, ack_level(pct_low));
        while (n_done == seen) begin
            if (noise && $urandom_range(0, 39) == 0) begin
                n_req++;
                send_item(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                          ack_level(pct_low));
            end else begin
                send_item(REQ_TICK, 8'($urandom), 8'($urandom), ack_level(pct_low));
            end
        end
    endtask

    // Waits until every request has come back and the bus is free.
    task automatic settle();
        while (n_popped != n_pushed || bus_open) begin
            if (n_popped == n_pushed) begin
                send_item(REQ_TICK, 8'($urandom), 8'($urandom), 1'b0);
            end else begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push <= 1'b0;
        repeat (6) @(posedge i_clk);
    endtask

    task automatic load_cfg(input logic [7:0] half, input logic [7:0] edg,
                            input logic [15:0] tmo, input logic [6:0] addr);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_HALF_BIT;
        i_cfg_data <= {8'($urandom), half};
        @(posedge i_clk);
        i_cfg_index <= CFG_EDGE;
        i_cfg_data <= {8'($urandom), edg};
        @(posedge i_clk);
        i_cfg_index <= CFG_ACK_TIMEOUT;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        i_cfg_index <= CFG_DEV_ADDR;
        i_cfg_data <= {9'($urandom), addr};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int   k;
        logic [7:0] half;
        logic [7:0] edg;
        logic [15:0] tmo;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_req_type <= REQ_TICK;
        i_reg_addr <= '0;
        i_write_value <= '0;
        i_sda_sample <= 1'b1;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_HALF_BIT;
        i_cfg_data <= '0;
        quiet <= 1'b0;
        n_pushed = 0;
        n_req = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default timing: a clean write, then the spare request code.
        run_txn(REQ_CODE_WRITE, 8'hFF, 8'h00, 100, 1'b0);
        send_item(REQ_CODE_SPARE, 8'hFF, 8'hFF, 1'b1);
        send_item(REQ_TICK, 8'h00, 8'h00, 1'b0);
        settle();

        // All-zero timing behaves as one tick per span.
        load_cfg(8'd0, 8'd0, 16'd0, 7'h7F);
        run_txn(REQ_CODE_READ, 8'h80, 8'h00, 100, 1'b0);
        run_txn(REQ_CODE_READ, 8'h7F, 8'h00, 0, 1'b0);
        run_txn(REQ_CODE_WRITE, 8'h01, 8'hFE, 60, 1'b1);

        while (n_pushed < 620) begin
            settle();
            half = 8'($urandom_range(0, 1));
            edg = 8'($urandom_range(0, 2));
            tmo = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            load_cfg(half, edg, tmo, 7'($urandom));
            for (k = 0; k < 2; k++) begin
                run_txn($urandom_range(0, 1) ? REQ_CODE_WRITE : REQ_CODE_READ,
                        8'($urandom), 8'($urandom), pick_ack_pct(), $urandom_range(0, 1) == 0);
                repeat ($urandom_range(0, 3))
                    send_item($urandom_range(0, 3) == 0 ? REQ_CODE_SPARE : REQ_TICK,
                              8'($urandom), 8'($urandom), 1'($urandom));
            end
        end

        settle();
        quiet <= 1'b1;
        load_cfg(8'd1, 8'd1, 16'd3, 7'($urandom));
        run_txn($urandom_range(0, 1) ? REQ_CODE_WRITE : REQ_CODE_READ,
                8'($urandom), 8'($urandom), 90, 1'b0);
        settle();
        repeat (8) @(posedge i_clk);

        if (fail_cnt == 0 && pending == 0)
            $display("[i2c_register_access_master] OK");
        else
            $display("[i2c_register_access_master] ERROR");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("[i2c_register_access_master] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/i2cram_pkg.sv
rtl/i2cram_front.sv
rtl/i2cram_seq.sv
rtl/i2cram_outq.sv
rtl/i2c_register_access_master.sv
sim/i2c_bus_checker.sv
sim/tb_top.sv
